[rtl/cke_pkg.sv]
// Package: shared constants, types and codes for the Coulomb and kinetic energy summer.
`default_nettype none
package cke_pkg;

  localparam int unsigned MaxParticles = 256;
  localparam int unsigned CntW         = $clog2(MaxParticles + 1);
  localparam int unsigned AddrW        = $clog2(MaxParticles);

  localparam int unsigned PosW  = 32;
  localparam int unsigned MassW = 24;
  localparam int unsigned ChgW  = 5;
  localparam int unsigned KinW  = 63;
  localparam int unsigned EnW   = 64;
  localparam int unsigned PcntW = 9;
  localparam int unsigned StatW = 2;

  // Square root of a 68-bit value gives 34 root bits; quotient has 42 bits.
  localparam int unsigned SqrtSteps = 34;
  localparam int unsigned DivSteps  = 42;
  localparam int unsigned StepW     = 6;

  typedef enum logic [StatW-1:0] {
    STAT_OK       = 2'd0,
    STAT_COINCIDE = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_VSQ, S_KMUL, S_KACC, S_RD, S_DIFF, S_DSQ,
    S_SQRT, S_DIV, S_ACC, S_STORE, S_DONE, S_EMIT
  } back_state_e;

  // Word passed from the front queue to the back engine
  typedef struct packed {
    logic signed [PosW-1:0]  pos_x;
    logic signed [PosW-1:0]  pos_y;
    logic signed [PosW-1:0]  pos_z;
    logic signed [PosW-1:0]  vel_x;
    logic signed [PosW-1:0]  vel_y;
    logic signed [PosW-1:0]  vel_z;
    logic [MassW-1:0]        mass;
    logic signed [ChgW-1:0]  charge;
    logic                    last;
    logic                    full;
    logic [CntW-1:0]         idx;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

  typedef struct packed {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic signed [PosW-1:0] z;
    logic signed [ChgW-1:0] charge;
  } store_t;

endpackage
`default_nettype wire

[rtl/cke_in_if.sv]
// Interface: input particle channel.
`default_nettype none
interface cke_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic [23:0]        particle_mass;
  logic signed [4:0]  particle_charge;
  logic               last_particle;

  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  particle_mass, particle_charge, last_particle, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                particle_mass, particle_charge, last_particle, output ready);
endinterface
`default_nettype wire

[rtl/cke_out_if.sv]
// Interface: energy result channel.
`default_nettype none
interface cke_out_if;
  logic               valid;
  logic               ready;
  logic [62:0]        kinetic_total;
  logic signed [63:0] coulomb_total;
  logic signed [63:0] energy_total;
  logic [8:0]         particle_count;
  logic [1:0]         status;

  modport source (output valid, kinetic_total, coulomb_total, energy_total,
                  particle_count, status, input ready);
  modport sink (input valid, kinetic_total, coulomb_total, energy_total,
                particle_count, status, output ready);
endinterface
`default_nettype wire

[rtl/cke_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none
module cke_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire                       clk_i,
  input  wire                       wr_en_i,
  input  wire [$clog2(Depth)-1:0]   wr_addr_i,
  input  wire [Width-1:0]           wr_data_i,
  input  wire                       rd_en_i,
  input  wire [$clog2(Depth)-1:0]   rd_addr_i,
  output logic [Width-1:0]          rd_data_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end
endmodule
`default_nettype wire

[rtl/cke_front.sv]
// Front end: accepts particles, tags store index and overflow, two-entry queue.
`default_nettype none
module cke_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  cke_in_if.sink              in_i,
  output cke_pkg::queue_out_t q_o,
  input  wire                 pop_i
);
  import cke_pkg::*;

  item_t           ent_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      fill_q;
  logic [CntW-1:0] cnt_q;
  logic            accept, full_store;
  item_t           new_item;

  assign in_i.ready = (fill_q != 2'd2);
  assign accept     = in_i.valid && in_i.ready;
  assign full_store = (cnt_q == CntW'(MaxParticles));

  // Classify the arriving word
  always_comb begin
    new_item.pos_x  = in_i.pos_x;
    new_item.pos_y  = in_i.pos_y;
    new_item.pos_z  = in_i.pos_z;
    new_item.vel_x  = in_i.vel_x;
    new_item.vel_y  = in_i.vel_y;
    new_item.vel_z  = in_i.vel_z;
    new_item.mass   = in_i.particle_mass;
    new_item.charge = in_i.particle_charge;
    new_item.last   = in_i.last_particle;
    new_item.full   = full_store;
    new_item.idx    = cnt_q;
  end

  assign q_o.valid = (fill_q != 2'd0);
  assign q_o.item  = ent_q[rd_ptr_q];

  // Store queue entries
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ent_q[wr_ptr_q] <= new_item;
    end
  end

  // Advance pointers, fill level and particle count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
      cnt_q    <= '0;
    end else begin
      if (accept) begin
        wr_ptr_q <= ~wr_ptr_q;
        if (in_i.last_particle) begin
          cnt_q <= '0;
        end else if (!full_store) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      fill_q <= fill_q + {1'b0, accept} - {1'b0, pop_i};
    end
  end
endmodule
`default_nettype wire

[rtl/cke_back.sv]
// Back end: kinetic term, pairwise distance, root and divide, accumulation, result.
`default_nettype none
module cke_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  cke_pkg::queue_out_t q_i,
  output logic                pop_o,
  cke_out_if.source           out_o
);
  import cke_pkg::*;

  back_state_e state_q, state_d;
  item_t       item_q;
  logic [1:0]  k_q, k_d;
  logic [StepW-1:0] step_q, step_d;
  logic [CntW-1:0]  i_q, i_d;
  logic [63:0] v2_q, v2_d;
  logic [87:0] p_q, p_d;
  logic [KinW-1:0] kin_q, kin_d;
  logic signed [EnW-1:0] coul_q, coul_d;
  logic [StatW-1:0] stat_q, stat_d;
  logic [32:0] dx_q, dy_q, dz_q;
  logic signed [9:0] qq_q;
  logic [67:0] s_q, s_d;
  logic [35:0] rem_q, rem_d;
  logic [33:0] root_q, root_d;
  logic [41:0] num_q, num_d;
  logic [33:0] drem_q, drem_d;
  logic        out_valid_q;
  logic        load_item, load_diff, emit;

  logic        ram_we, ram_re;
  store_t      ram_wdata, ram_rdata;

  logic [31:0] vsel;
  logic [63:0] vsq;
  logic [32:0] dsel;
  logic [65:0] dsq;
  logic [55:0] mprod;
  logic [63:0] kin_sum;
  logic [37:0] rem_t, trial;
  logic [34:0] div_t;
  logic [8:0]  mag;
  logic signed [EnW:0] csum, esum;
  logic signed [EnW-1:0] term, esat;
  logic signed [32:0] dxs, dys, dzs;
  logic signed [9:0]  qq_n;

  cke_ram #(.Width($bits(store_t)), .Depth(MaxParticles)) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (item_q.idx[AddrW-1:0]),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (i_q[AddrW-1:0]),
    .rd_data_o (ram_rdata)
  );

  assign ram_wdata.x      = item_q.pos_x;
  assign ram_wdata.y      = item_q.pos_y;
  assign ram_wdata.z      = item_q.pos_z;
  assign ram_wdata.charge = item_q.charge;

  // Datapath helpers
  always_comb begin
    unique case (k_q)
      2'd0:    vsel = item_q.vel_x[31] ? 32'(-item_q.vel_x) : 32'(item_q.vel_x);
      2'd1:    vsel = item_q.vel_y[31] ? 32'(-item_q.vel_y) : 32'(item_q.vel_y);
      default: vsel = item_q.vel_z[31] ? 32'(-item_q.vel_z) : 32'(item_q.vel_z);
    endcase
    unique case (k_q)
      2'd0:    dsel = dx_q;
      2'd1:    dsel = dy_q;
      default: dsel = dz_q;
    endcase
    vsq   = vsel * vsel;
    dsq   = dsel * dsel;
    mprod = (k_q == 2'd0) ? v2_q[31:0] * item_q.mass : v2_q[63:32] * item_q.mass;
    kin_sum = {1'b0, kin_q} + {1'b0, p_q[87:25]};
    rem_t = {rem_q, s_q[67:66]};
    trial = {2'b00, root_q, 2'b01};
    div_t = {drem_q, num_q[41]};
    mag   = qq_q[9] ? 9'(-qq_q) : 9'(qq_q);
    term  = qq_q[9] ? -EnW'($signed({1'b0, num_q})) : EnW'($signed({1'b0, num_q}));
    csum  = {coul_q[EnW-1], coul_q} + {term[EnW-1], term};
    esum  = {1'b0, $signed({1'b0, kin_q})} + {coul_q[EnW-1], coul_q};
    esat  = (esum[EnW] != esum[EnW-1]) ?
            (esum[EnW] ? {1'b1, {(EnW-1){1'b0}}} : {1'b0, {(EnW-1){1'b1}}}) :
            esum[EnW-1:0];
    dxs = {item_q.pos_x[31], item_q.pos_x} - {ram_rdata.x[31], ram_rdata.x};
    dys = {item_q.pos_y[31], item_q.pos_y} - {ram_rdata.y[31], ram_rdata.y};
    dzs = {item_q.pos_z[31], item_q.pos_z} - {ram_rdata.z[31], ram_rdata.z};
    qq_n = item_q.charge * ram_rdata.charge;
  end

  // Sequence one particle
  always_comb begin
    state_d = state_q;
    k_d = k_q; step_d = step_q; i_d = i_q;
    v2_d = v2_q; p_d = p_q; kin_d = kin_q; coul_d = coul_q; stat_d = stat_q;
    s_d = s_q; rem_d = rem_q; root_d = root_q; num_d = num_q; drem_d = drem_q;
    pop_o = 1'b0; load_item = 1'b0; load_diff = 1'b0; emit = 1'b0;
    ram_we = 1'b0; ram_re = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (q_i.valid) begin
          pop_o = 1'b1;
          load_item = 1'b1;
          k_d = 2'd0;
          v2_d = '0;
          if (q_i.item.full) begin
            stat_d = STAT_OVERFLOW;
            state_d = S_DONE;
          end else begin
            state_d = S_VSQ;
          end
        end
      end
      S_VSQ: begin
        v2_d = v2_q + vsq;
        k_d = k_q + 2'd1;
        if (k_q == 2'd2) begin
          k_d = 2'd0;
          p_d = '0;
          state_d = S_KMUL;
        end
      end
      S_KMUL: begin
        if (k_q == 2'd0) begin
          p_d = 88'(mprod);
          k_d = 2'd1;
        end else begin
          p_d = p_q + {mprod, 32'b0};
          state_d = S_KACC;
        end
      end
      S_KACC: begin
        kin_d = kin_sum[63] ? {KinW{1'b1}} : kin_sum[KinW-1:0];
        i_d = '0;
        state_d = (item_q.idx == '0) ? S_STORE : S_RD;
      end
      S_RD: begin
        ram_re = 1'b1;
        state_d = S_DIFF;
      end
      S_DIFF: begin
        load_diff = 1'b1;
        k_d = 2'd0;
        s_d = '0;
        state_d = S_DSQ;
      end
      S_DSQ: begin
        s_d = s_q + 68'(dsq);
        k_d = k_q + 2'd1;
        if (k_q == 2'd2) begin
          k_d = 2'd0;
          rem_d = '0;
          root_d = '0;
          step_d = '0;
          if (s_d == '0) begin
            if (stat_q == STAT_OK) begin
              stat_d = STAT_COINCIDE;
            end
            i_d = i_q + 1'b1;
            state_d = ((i_q + 1'b1) == item_q.idx) ? S_STORE : S_RD;
          end else begin
            state_d = S_SQRT;
          end
        end
      end
      S_SQRT: begin
        s_d = {s_q[65:0], 2'b00};
        if (rem_t >= trial) begin
          rem_d = 36'(rem_t - trial);
          root_d = {root_q[32:0], 1'b1};
        end else begin
          rem_d = rem_t[35:0];
          root_d = {root_q[32:0], 1'b0};
        end
        step_d = step_q + 1'b1;
        if (step_q == StepW'(SqrtSteps - 1)) begin
          step_d = '0;
          drem_d = '0;
          num_d = 42'({mag, 32'b0}) + 42'(root_d[33:1]);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_t >= {1'b0, root_q}) begin
          drem_d = 34'(div_t - {1'b0, root_q});
          num_d = {num_q[40:0], 1'b1};
        end else begin
          drem_d = div_t[33:0];
          num_d = {num_q[40:0], 1'b0};
        end
        step_d = step_q + 1'b1;
        if (step_q == StepW'(DivSteps - 1)) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        if (csum[EnW] != csum[EnW-1]) begin
          coul_d = csum[EnW] ? {1'b1, {(EnW-1){1'b0}}} : {1'b0, {(EnW-1){1'b1}}};
        end else begin
          coul_d = csum[EnW-1:0];
        end
        i_d = i_q + 1'b1;
        state_d = ((i_q + 1'b1) == item_q.idx) ? S_STORE : S_RD;
      end
      S_STORE: begin
        ram_we = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = item_q.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          emit = 1'b1;
          kin_d = '0;
          coul_d = '0;
          stat_d = STAT_OK;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the working particle and pair operands
  always_ff @(posedge clk_i) begin
    if (load_item) begin
      item_q <= q_i.item;
    end
    if (load_diff) begin
      dx_q <= dxs[32] ? 33'(-dxs) : 33'(dxs);
      dy_q <= dys[32] ? 33'(-dys) : 33'(dys);
      dz_q <= dzs[32] ? 33'(-dzs) : 33'(dzs);
      qq_q <= qq_n;
    end
    v2_q <= v2_d; p_q <= p_d; s_q <= s_d; rem_q <= rem_d; root_q <= root_d;
    num_q <= num_d; drem_q <= drem_d;
    if (emit) begin
      out_o.kinetic_total  <= kin_q;
      out_o.coulomb_total  <= coul_q;
      out_o.energy_total   <= esat;
      out_o.particle_count <= item_q.full ? PcntW'(item_q.idx)
                                          : PcntW'(item_q.idx + 1'b1);
      out_o.status         <= stat_q;
    end
  end

  // Control state and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q <= '0; step_q <= '0; i_q <= '0;
      kin_q <= '0; coul_q <= '0; stat_q <= STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q <= k_d; step_q <= step_d; i_q <= i_d;
      kin_q <= kin_d; coul_q <= coul_d; stat_q <= stat_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid = out_valid_q;
endmodule
`default_nettype wire

[rtl/coulomb_kinetic_energy_sum.sv]
// Top level: particle energy summer with a decoupled front queue and back engine.
// Usage:
//   in_i carries one particle per word: position and velocity (Q15.16), mass
//   (Q16.8), integer charge and a last flag. out_o carries one result word per
//   set: kinetic, Coulomb and total energy (Q47.16, saturating), the particle
//   count and a status (ok, coincident positions, store overflow).
//   Work: a particle stored as number n is paired with the n particles stored
//   before it in the back engine. Each stored pair costs a read, a difference
//   step, squaring of the three axes, 34 square-root steps, 42 divide steps and
//   an accumulate step; a coincident pair stops after the squaring. A particle
//   past the store size skips the kinetic and pair work. The result word is
//   registered after the last particle's pairs, via the store and done states.
//   A two-word queue lets the sender run ahead while the engine works.
//   Reset clears counts, accumulators, the queue and the result valid flag; the
//   position store needs no clearing since only written entries are read.
//   A stalled receiver holds the result register; the engine waits at the
//   next result, while the queue keeps taking particles until it is full.
`default_nettype none
module coulomb_kinetic_energy_sum (
  input  wire        clk_i,
  input  wire        rst_ni,
  cke_in_if.sink     in_i,
  cke_out_if.source  out_o
);
  import cke_pkg::*;

  queue_out_t q;
  logic       pop;

  cke_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .q_o    (q),
    .pop_i  (pop)
  );

  cke_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_i    (q),
    .pop_o  (pop),
    .out_o  (out_o)
  );
endmodule
`default_nettype wire

[tb/coulomb_kinetic_energy_sum_tb.sv]
// Testbench: self-checking stimulus, energy predictor and result scoreboard for the summer.
`timescale 1ns / 100ps
module coulomb_kinetic_energy_sum_tb;
  import cke_pkg::*;

  localparam longint unsigned Sat63   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint          CycLimit = 40_000_000;
  localparam int              HoldOff  = 3000;

  typedef struct {
    logic signed [PosW-1:0]  px, py, pz;
    logic signed [PosW-1:0]  vx, vy, vz;
    logic [MassW-1:0]        mass;
    logic signed [ChgW-1:0]  charge;
    logic                    last;
  } particle_t;

  typedef struct {
    logic [KinW-1:0]        kinetic;
    logic signed [EnW-1:0]  coulomb;
    logic signed [EnW-1:0]  energy;
    logic [PcntW-1:0]       count;
    status_e                status;
  } energy_t;

  typedef struct {
    particle_t  p;
    logic       typed;
    energy_t    e;
  } row_t;

  logic clk_i;
  logic rst_ni;
  cke_in_if  in_bus ();
  cke_out_if out_bus ();

  coulomb_kinetic_energy_sum dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Predictor state: stored particles, accumulators, worst status
  logic signed [PosW-1:0] set_x [MaxParticles];
  logic signed [PosW-1:0] set_y [MaxParticles];
  logic signed [PosW-1:0] set_z [MaxParticles];
  logic signed [ChgW-1:0] set_q [MaxParticles];
  int unsigned            set_count;
  logic [63:0]            kinetic_sum;
  logic signed [63:0]     coulomb_sum;
  status_e                worst_status;

  energy_t   expected_energy_q [$];
  int        errors;
  int        gap_pct;
  int        stall_pct;
  bit        hold_off;
  longint    cycles;

  always #5 clk_i = ~clk_i;

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    if (errors < 40) $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic logic signed [63:0] add_clamped(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
    logic signed [64:0] t;
    t = {a[63], a} + {b[63], b};
    if (t[64] != t[63]) return t[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    return t[63:0];
  endfunction

  function automatic logic [63:0] abs_diff(input longint a, input longint b);
    longint d;
    d = a - b;
    return (d < 0) ? -d : d;
  endfunction

  function automatic logic [63:0] floor_root(input logic [127:0] s);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 35; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= s) r = c;
    end
    return r[63:0];
  endfunction

  // Add one particle to the sums; queue a result when it closes the set
  task automatic accumulate_particle(input particle_t p, input logic typed, input energy_t te);
    logic [63:0]        ax, ay, az, v2, ke, dx, dy, dz, r, mag, term;
    logic [127:0]       prod, dsq;
    longint             qq;
    energy_t            e;
    if (set_count >= MaxParticles) begin
      worst_status = STAT_OVERFLOW;
    end else begin
      ax = abs_diff(p.vx, 0);
      ay = abs_diff(p.vy, 0);
      az = abs_diff(p.vz, 0);
      v2 = ax * ax + ay * ay + az * az;
      prod = {64'b0, v2} * {104'b0, p.mass};
      prod = prod >> 25;
      ke = (prod > Sat63) ? Sat63 : prod[63:0];
      kinetic_sum = kinetic_sum + ke;
      if (kinetic_sum > Sat63) kinetic_sum = Sat63;
      for (int i = 0; i < set_count; i++) begin
        dx = abs_diff(p.px, set_x[i]);
        dy = abs_diff(p.py, set_y[i]);
        dz = abs_diff(p.pz, set_z[i]);
        dsq = {64'b0, dx} * dx + {64'b0, dy} * dy + {64'b0, dz} * dz;
        qq = longint'(p.charge) * longint'(set_q[i]);
        if (dsq == 0) begin
          if (worst_status == STAT_OK) worst_status = STAT_COINCIDE;
        end else begin
          r = floor_root(dsq);
          if (r == 0) r = 1;
          mag = (qq < 0) ? -qq : qq;
          term = ((mag << 32) + (r >> 1)) / r;
          coulomb_sum = add_clamped(coulomb_sum, (qq < 0) ? -term : term);
        end
      end
      set_x[set_count] = p.px;
      set_y[set_count] = p.py;
      set_z[set_count] = p.pz;
      set_q[set_count] = p.charge;
      set_count++;
    end
    if (p.last) begin
      e.kinetic = kinetic_sum[62:0];
      e.coulomb = coulomb_sum;
      e.energy  = add_clamped(kinetic_sum, coulomb_sum);
      e.count   = set_count[8:0];
      e.status  = worst_status;
      if (typed) e = te;
      expected_energy_q.insert(expected_energy_q.size(), e);
      set_count    = 0;
      kinetic_sum  = '0;
      coulomb_sum  = '0;
      worst_status = STAT_OK;
    end
  endtask

  // Offer one word, with an optional idle gap first; hold until accepted
  task automatic offer_particle(input particle_t p, input logic typed, input energy_t te);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    in_bus.valid           <= 1'b1;
    in_bus.pos_x           <= p.px;
    in_bus.pos_y           <= p.py;
    in_bus.pos_z           <= p.pz;
    in_bus.vel_x           <= p.vx;
    in_bus.vel_y           <= p.vy;
    in_bus.vel_z           <= p.vz;
    in_bus.particle_mass   <= p.mass;
    in_bus.particle_charge <= p.charge;
    in_bus.last_particle   <= p.last;
    do @(posedge clk_i); while (!in_bus.ready);
    accumulate_particle(p, typed, te);
  endtask

  function automatic logic [31:0] rand_coord();
    return $urandom_range(2 ** 21) - 32'd1048576;
  endfunction

  // Send one set of n particles with random content
  task automatic send_set(input int n);
    particle_t p;
    particle_t seen [$];
    energy_t   none;
    int        k;
    none = '{kinetic: '0, coulomb: '0, energy: '0, count: '0, status: STAT_OK};
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(9);
      if (k == 0) begin
        p.px = $urandom; p.py = $urandom; p.pz = $urandom;
      end else if (k == 1 && seen.size() > 0) begin
        p = seen[$urandom_range(seen.size() - 1)];
      end else begin
        p.px = rand_coord(); p.py = rand_coord(); p.pz = rand_coord();
      end
      k = $urandom_range(9);
      if (k == 0) begin
        p.vx = $urandom; p.vy = $urandom; p.vz = $urandom;
      end else if (k == 1) begin
        p.vx = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        p.vy = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        p.vz = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end else begin
        p.vx = rand_coord(); p.vy = rand_coord(); p.vz = rand_coord();
      end
      k = $urandom_range(15);
      p.mass   = (k == 0) ? '0 : (k == 1) ? '1 : MassW'($urandom);
      p.charge = ChgW'($urandom_range(31));
      p.last   = (i == n - 1);
      seen.insert(seen.size(), p);
      offer_particle(p, 1'b0, none);
    end
  endtask

  task automatic random_sets(input int target);
    int sent;
    int n;
    sent = 0;
    while (sent < target) begin
      n = ($urandom_range(19) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 8);
      send_set(n);
      sent += n;
    end
  endtask

  // Check each accepted result against the oldest expectation; drive ready
  always @(posedge clk_i) begin
    energy_t e;
    if (out_bus.valid && out_bus.ready) begin
      if (expected_energy_q.size() == 0) begin
        report("unexpected result", 64'(out_bus.particle_count), 64'd0);
      end else begin
        e = expected_energy_q.pop_front();
        if (out_bus.kinetic_total !== e.kinetic)
          report("kinetic", 64'(out_bus.kinetic_total), 64'(e.kinetic));
        if (out_bus.coulomb_total !== e.coulomb)
          report("coulomb", out_bus.coulomb_total, e.coulomb);
        if (out_bus.energy_total !== e.energy)
          report("energy", out_bus.energy_total, e.energy);
        if (out_bus.particle_count !== e.count)
          report("count", 64'(out_bus.particle_count), 64'(e.count));
        if (out_bus.status !== e.status)
          report("status", 64'(out_bus.status), 64'(e.status));
      end
    end
    out_bus.ready <= rst_ni && !hold_off && ($urandom_range(99) >= stall_pct);
  end

  initial begin
    row_t      rows [$];
    particle_t big;
    energy_t   none;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cycles = 0;
    errors = 0;
    gap_pct = 0;
    stall_pct = 0;
    hold_off = 1'b0;
    set_count = 0;
    kinetic_sum = '0;
    coulomb_sum = '0;
    worst_status = STAT_OK;
    none = '{kinetic: '0, coulomb: '0, energy: '0, count: '0, status: STAT_OK};
    in_bus.valid = 1'b0;
    in_bus.pos_x = '0; in_bus.pos_y = '0; in_bus.pos_z = '0;
    in_bus.vel_x = '0; in_bus.vel_y = '0; in_bus.vel_z = '0;
    in_bus.particle_mass = '0;
    in_bus.particle_charge = '0;
    in_bus.last_particle = 1'b0;
    out_bus.ready = 1'b0;

    // Directed rows: lone particle at rest, top speed and mass, unit distance,
    // coincident pair, corner positions, zero mass, alternating bit patterns
    rows = '{
      '{'{0, 0, 0, 0, 0, 0, 0, 0, 1}, 1,
        '{0, 0, 0, 1, STAT_OK}},
      '{'{0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFFFFFF, 0, 1}, 0,
        '{0, 0, 0, 0, STAT_OK}},
      '{'{0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 3, 1}, 0,
        '{0, 0, 0, 0, STAT_OK}},
      '{'{0, 0, 0, 0, 0, 0, 24'h000100, 1, 0}, 0, '{0, 0, 0, 0, STAT_OK}},
      '{'{32'h0001_0000, 0, 0, 0, 0, 0, 24'h000100, 1, 1}, 1,
        '{0, 65536, 65536, 2, STAT_OK}},
      '{'{100, 200, 300, 0, 0, 0, 5, 5, 0}, 0, '{0, 0, 0, 0, STAT_OK}},
      '{'{100, 200, 300, 0, 0, 0, 7, 3, 1}, 1,
        '{0, 0, 0, 2, STAT_COINCIDE}},
      '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 2, 3, 9, 5'h10, 0}, 0,
        '{0, 0, 0, 0, STAT_OK}},
      '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 4, 5, 6, 9, 5'h0F, 1}, 0,
        '{0, 0, 0, 0, STAT_OK}},
      '{'{10, 20, 30, 1000, 0, 0, 24'h0000FF, -8, 0}, 0, '{0, 0, 0, 0, STAT_OK}},
      '{'{10, 20, 30, 0, 1000, 0, 24'h000001, 8, 0}, 0, '{0, 0, 0, 0, STAT_OK}},
      '{'{32'h0004_0000, 32'hFFFF_0000, 7, 0, 0, 1000, 24'h800000, -1, 1}, 0,
        '{0, 0, 0, 0, STAT_OK}},
      '{'{32'h8000_0000, 0, 0, 32'h8000_0000, 0, 0, 24'hFFFFFF, 5'h1F, 1}, 0,
        '{0, 0, 0, 0, STAT_OK}},
      '{'{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
          32'hAAAA_AAAA, 24'h555555, 5'h15, 0}, 0, '{0, 0, 0, 0, STAT_OK}},
      '{'{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
          32'h5555_5555, 24'hAAAAAA, 5'h0A, 1}, 0, '{0, 0, 0, 0, STAT_OK}}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) offer_particle(rows[i].p, rows[i].typed, rows[i].e);

    // Random phases with different idling on each side
    random_sets(380);
    // One set past the store size: overflow with a full count
    for (int i = 0; i <= MaxParticles; i++) begin
      big.px = rand_coord(); big.py = rand_coord(); big.pz = rand_coord();
      big.vx = rand_coord(); big.vy = rand_coord(); big.vz = rand_coord();
      big.mass = MassW'($urandom);
      big.charge = ChgW'($urandom_range(31));
      big.last = (i == MaxParticles);
      offer_particle(big, 1'b0, none);
    end
    gap_pct = 83; stall_pct = 0;
    random_sets(320);
    gap_pct = 0; stall_pct = 83;
    random_sets(320);
    gap_pct = 9; stall_pct = 9;
    random_sets(320);

    // Hold off the receiver while single-particle sets keep coming
    gap_pct = 0; stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (HoldOff) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        repeat (40) send_set(1);
        in_bus.valid <= 1'b0;
      end
    join

    // Drain outstanding results, then let the engine settle
    while (expected_energy_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
